// ===== hdl/pts_pkg.sv =====
// Shared types and constants for the priority tick scheduler.
// Used by pts_controller, pts_datapath and priority_tick_scheduler; no dependencies.
package pts_pkg;

   // Number of task slots, slot zero being the idle task.
   localparam int TASK_SLOTS = 16;
   localparam int SLOT_W     = $clog2(TASK_SLOTS);

   // Item opcodes.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // Input item.
   typedef struct packed {
      logic       opcode;
      logic [3:0] slot;
      logic       present;
      logic       runnable;
      logic [7:0] time_left;
      logic [6:0] weight;
   } pts_req_type;

   // Result item.
   typedef struct packed {
      logic [3:0] current_task;
      logic       switched;
      logic       rescheduled;
      logic       refilled;
      logic       stuck_flag;
   } pts_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic check;
      logic scan_start;
      logic scan_step;
      logic refill_start;
      logic refill_step;
      logic finish;
   } pts_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic go;
      logic idx_last;
      logic best_zero;
      logic refilled;
   } pts_stat_type;

endpackage

// ===== hdl/pts_controller.sv =====
// Sequencing state machine of the priority tick scheduler.
// Depends on pts_pkg; drives the command struct of pts_datapath.
module pts_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  pts_pkg::pts_req_type  req_item,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  pts_pkg::pts_stat_type stat,
   output pts_pkg::pts_cmd_type  cmd
);
   import pts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_REFILL,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new item when empty or draining.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               if (req_item.opcode == OP_LOAD) begin
                  cmd.load     = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            cmd.check      = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = stat.go ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.idx_last) begin
               if (stat.best_zero && !stat.refilled) begin
                  cmd.refill_start = 1'b1;
                  state_in         = ST_REFILL;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_REFILL: begin
            cmd.refill_step = 1'b1;
            if (stat.idx_last) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/pts_datapath.sv =====
// Slot table, scan registers and result register of the priority tick scheduler.
// Depends on pts_pkg; commanded by pts_controller.
module pts_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  pts_pkg::pts_req_type  req_item,
   input  pts_pkg::pts_cmd_type  cmd,
   output pts_pkg::pts_stat_type stat,
   output pts_pkg::pts_rsp_type  rsp_item
);
   import pts_pkg::*;

   localparam logic [SLOT_W-1:0] IDX_TOP = SLOT_W'(TASK_SLOTS - 1);
   localparam logic [SLOT_W-1:0] IDX_ONE = SLOT_W'(1);

   // Slot table.
   logic       present_ff  [TASK_SLOTS];
   logic       running_ff  [TASK_SLOTS];
   logic [7:0] counter_ff  [TASK_SLOTS];
   logic [6:0] priority_ff [TASK_SLOTS];

   logic [SLOT_W-1:0] cur_ff, idx_ff, best_ff;
   logic [7:0]        cnt_ff;
   logic              found_ff, go_ff, refl_ff;
   pts_rsp_type       rsp_ff;

   logic [SLOT_W-1:0] rd_idx, wr_slot, next_slot;
   logic              rd_present, rd_running;
   logic [7:0]        rd_cnt, refill_cnt;
   logic              load_ok, cur_idle, take, found_nx, stuck;
   logic [7:0]        cnt_nx;

   // One table read port: the current slot during the check, else the walk index.
   assign rd_idx     = cmd.check ? cur_ff : idx_ff;
   assign rd_present = present_ff[rd_idx];
   assign rd_running = running_ff[rd_idx];
   assign rd_cnt     = counter_ff[rd_idx];
   assign refill_cnt = {1'b0, rd_cnt[7:1]} + {1'b0, priority_ff[rd_idx]};

   // Loads to the idle slot or beyond the table are dropped.
   assign wr_slot = SLOT_W'(req_item.slot);
   assign load_ok = (req_item.slot != 4'd0) && (32'(req_item.slot) < TASK_SLOTS);

   // Tick check of the current task.
   assign cur_idle = (cur_ff == '0);

   // Scan compare: first running slot seen, or a strictly larger counter.
   assign take     = rd_present && rd_running && (!found_ff || (rd_cnt > cnt_ff));
   assign found_nx = found_ff || take;
   assign cnt_nx   = take ? rd_cnt : cnt_ff;

   // A zero best after the second scan selects idle.
   assign stuck     = found_ff && (cnt_ff == 8'd0);
   assign next_slot = stuck ? '0 : best_ff;

   assign stat.go        = cur_idle || (rd_cnt == 8'd0) || (rd_cnt == 8'd1);
   assign stat.idx_last  = (idx_ff == IDX_ONE);
   assign stat.best_zero = found_nx && (cnt_nx == 8'd0);
   assign stat.refilled  = refl_ff;

   assign rsp_item = rsp_ff;

   // Table writes: load, decrement of the current task, refill of one slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TASK_SLOTS; i++) begin
            present_ff[i]  <= 1'b0;
            running_ff[i]  <= 1'b0;
            counter_ff[i]  <= 8'd0;
            priority_ff[i] <= 7'd0;
         end
      end else if (cmd.load) begin
         if (load_ok) begin
            present_ff[wr_slot]  <= req_item.present;
            running_ff[wr_slot]  <= req_item.runnable;
            counter_ff[wr_slot]  <= req_item.time_left;
            priority_ff[wr_slot] <= req_item.weight;
         end
      end else if (cmd.check) begin
         if (!cur_idle && (rd_cnt != 8'd0)) begin
            counter_ff[cur_ff] <= rd_cnt - 8'd1;
         end
      end else if (cmd.refill_step) begin
         if (rd_present) begin
            counter_ff[idx_ff] <= refill_cnt;
         end
      end
   end

   // Walk index, scan result, pass flags and current slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff   <= '0;
         idx_ff   <= IDX_TOP;
         best_ff  <= '0;
         cnt_ff   <= 8'd0;
         found_ff <= 1'b0;
         go_ff    <= 1'b0;
         refl_ff  <= 1'b0;
      end else begin
         if (cmd.scan_start || cmd.refill_start) begin
            idx_ff <= IDX_TOP;
         end else if (cmd.scan_step || cmd.refill_step) begin
            idx_ff <= idx_ff - IDX_ONE;
         end
         if (cmd.scan_start) begin
            best_ff  <= '0;
            cnt_ff   <= 8'd0;
            found_ff <= 1'b0;
         end else if (cmd.scan_step && take) begin
            best_ff  <= idx_ff;
            cnt_ff   <= rd_cnt;
            found_ff <= 1'b1;
         end
         if (cmd.check) begin
            go_ff   <= stat.go;
            refl_ff <= 1'b0;
         end else if (cmd.refill_start) begin
            refl_ff <= 1'b1;
         end
         if (cmd.finish && go_ff) begin
            cur_ff <= next_slot;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load || (cmd.finish && !go_ff)) begin
         rsp_ff <= '{current_task: 4'(cur_ff), switched: 1'b0, rescheduled: 1'b0,
                     refilled: 1'b0, stuck_flag: 1'b0};
      end else if (cmd.finish) begin
         rsp_ff <= '{current_task: 4'(next_slot), switched: (next_slot != cur_ff),
                     rescheduled: 1'b1, refilled: refl_ff, stuck_flag: stuck};
      end
   end

endmodule

// ===== hdl/priority_tick_scheduler.sv =====
// Top level of the priority tick scheduler: controller plus datapath.
// Depends on pts_pkg, pts_controller and pts_datapath.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | req_item (pts_req_type)
//   rsp     | out       | rsp_valid/rsp_ready | rsp_item (pts_rsp_type)
//
// A load item's result is registered and appears in the cycle after it is taken.
// A tick runs a check and a finish; a reschedule adds a scan of the table,
// and a scan that finds a zero best counter adds a refill and a second scan; the
// table has one read port, walked one slot per cycle for scans and refills.
// Synchronous reset clears the slot table and selects the idle task.
// A stalled result stays in the output register; a new item is taken once
// that register is empty or draining.
module priority_tick_scheduler (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pts_pkg::pts_req_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pts_pkg::pts_rsp_type rsp_item
);
   import pts_pkg::*;

   pts_cmd_type  cmd;
   pts_stat_type stat;

   pts_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pts_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_item (rsp_item)
   );

`ifndef SYNTHESIS
   // A table load happens only on an accepted item.
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && req_ready))
      else $error("table load without an accepted item");

   // A finished tick always leaves a result waiting.
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished tick produced no result");

   // At most one refill per tick.
   a_one_refill: assert property (@(posedge clock) disable iff (reset)
      cmd.refill_start |-> !stat.refilled)
      else $error("second refill within one tick");

   // A stuck outcome follows a refill and selects idle.
   a_stuck_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.stuck_flag) |->
         (rsp_item.refilled && (rsp_item.current_task == 4'd0)))
      else $error("stuck result without refill or not idle");
`endif

endmodule
